@@ rtl/tshc_pkg.sv @@
package tshc_pkg;

  localparam int FracBits = 16;
  localparam int NumSteps = 5;
  localparam int DivStages = FracBits;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_LAST  = 2'd1,
    MODE_DUR   = 2'd2,
    MODE_NONE  = 2'd3
  } time_mode_t;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_LOWER   = 2'd1,
    REG_UPPER   = 2'd2,
    REG_INVALID = 2'd3
  } reg_idx_t;

  typedef logic [7:0] chan_t;
  typedef chan_t [3:0] rgba_t;

  localparam logic [31:0] InvalidReset = 32'h00FF00FF;

  function automatic rgba_t heat_step(input logic [2:0] idx);
    rgba_t c;
    begin
      unique case (idx)
        3'd0: c = '{8'd0, 8'd0, 8'd0, 8'd255};
        3'd1: c = '{8'd145, 8'd20, 8'd145, 8'd255};
        3'd2: c = '{8'd255, 8'd138, 8'd0, 8'd255};
        3'd3: c = '{8'd255, 8'd230, 8'd40, 8'd255};
        default: c = '{8'd255, 8'd255, 8'd255, 8'd255};
      endcase
      return c;
    end
  endfunction

endpackage

@@ rtl/timestamp_heat_colormap.sv @@
// Pipeline: a word presented with start passes the stage 1, stage 2, divider and output registers
// to reach the out_ ports, out_valid marking it for a single cycle.
// Throughput: one word per cycle; the fraction is worked out by a sixteen-stage
// restoring divider, one quotient bit per stage, and busy is never raised.
// Reset: synchronous and active low; it clears all valid bits and restores the configuration registers.
module timestamp_heat_colormap import tshc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_first_seen_valid,
  input  logic [63:0] in_first_seen_time,
  input  logic        in_last_seen_valid,
  input  logic [63:0] in_last_seen_time,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_time_missing,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [FracBits-1:0] Half = FracBits'(1) << (FracBits - 1);

  typedef enum logic [1:0] {
    CLS_MISS  = 2'd0,
    CLS_DARK  = 2'd1,
    CLS_LIGHT = 2'd2,
    CLS_BLEND = 2'd3
  } cls_t;

  time_mode_t  mode_r;
  logic [63:0] lower_r, upper_r;
  logic [31:0] invalid_r;
  reg_idx_t    ridx;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign ridx   = reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_LAST;
      lower_r   <= '0;
      upper_r   <= '0;
      invalid_r <= InvalidReset;
    end else if (wr_en) begin
      unique case (ridx)
        REG_MODE:    mode_r    <= time_mode_t'(pwdata[1:0]);
        REG_LOWER:   lower_r   <= pwdata;
        REG_UPPER:   upper_r   <= pwdata;
        REG_INVALID: invalid_r <= pwdata[31:0];
        default:     mode_r    <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MODE:    prdata = {62'd0, mode_r};
      REG_LOWER:   prdata = lower_r;
      REG_UPPER:   prdata = upper_r;
      REG_INVALID: prdata = {32'd0, invalid_r};
      default:     prdata = '0;
    endcase
  end

  // Stage 1: select the value and check presence.
  logic        s1_vld_r, s1_pres_r;
  logic [63:0] s1_val_r;
  logic        pres_nxt;
  logic [63:0] val_nxt;

  always_comb begin
    pres_nxt = 1'b0;
    val_nxt  = '0;
    unique case (mode_r)
      MODE_FIRST: begin
        pres_nxt = in_first_seen_valid && (in_first_seen_time != '0);
        val_nxt  = in_first_seen_time;
      end
      MODE_LAST: begin
        pres_nxt = in_last_seen_valid && (in_last_seen_time != '0);
        val_nxt  = in_last_seen_time;
      end
      MODE_DUR: begin
        pres_nxt = in_first_seen_valid && in_last_seen_valid &&
                   (in_first_seen_time != '0) && (in_last_seen_time != '0) &&
                   (in_last_seen_time >= in_first_seen_time);
        val_nxt  = in_last_seen_time - in_first_seen_time;
      end
      default: begin
        pres_nxt = 1'b0;
        val_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
    s1_pres_r <= pres_nxt;
    s1_val_r  <= val_nxt;
  end

  // Stage 2: classify against the bounds and form numerator and denominator.
  logic        s2_vld_r;
  cls_t        s2_cls_r;
  logic [63:0] s2_num_r, s2_den_r;
  cls_t        cls_nxt;

  always_comb begin
    priority if (!s1_pres_r)                                   cls_nxt = CLS_MISS;
    else if (s1_val_r <= lower_r || lower_r == upper_r)        cls_nxt = CLS_DARK;
    else if (s1_val_r >= upper_r)                              cls_nxt = CLS_LIGHT;
    else                                                       cls_nxt = CLS_BLEND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_cls_r <= cls_nxt;
    s2_num_r <= s1_val_r - lower_r;
    s2_den_r <= upper_r - lower_r;
  end

  // Divider stages: one quotient bit each, remainder kept below the divisor for blend entries.
  logic                dv_vld_r [DivStages];
  cls_t                dv_cls_r [DivStages];
  logic [63:0]         dv_rem_r [DivStages];
  logic [63:0]         dv_den_r [DivStages];
  logic [FracBits-1:0] dv_q_r   [DivStages];

  for (genvar i = 0; i < DivStages; i++) begin : g_div
    logic                vin;
    cls_t                cin;
    logic [63:0]         rin, din, diff;
    logic [FracBits-1:0] qin;
    logic                ge;
    if (i == 0) begin : g_head
      assign vin = s2_vld_r;
      assign cin = s2_cls_r;
      assign rin = s2_num_r;
      assign din = s2_den_r;
      assign qin = '0;
    end else begin : g_body
      assign vin = dv_vld_r[i-1];
      assign cin = dv_cls_r[i-1];
      assign rin = dv_rem_r[i-1];
      assign din = dv_den_r[i-1];
      assign qin = dv_q_r[i-1];
    end
    assign diff = din - rin;
    assign ge   = rin >= diff;
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[i] <= 1'b0;
      else        dv_vld_r[i] <= vin;
      dv_cls_r[i] <= cin;
      dv_den_r[i] <= din;
      dv_rem_r[i] <= ge ? (rin - diff) : {rin[62:0], 1'b0};
      dv_q_r[i]   <= {qin[FracBits-2:0], ge};
    end
  end

  // Blend stage: pick segment and weight, mix each channel with rounding.
  logic                q_vld;
  cls_t                q_cls;
  logic [FracBits-1:0] q_val, wgt;
  logic [2:0]          seg;
  rgba_t               ca, cb, mix;
  logic [FracBits+8:0] acc [4];

  assign q_vld = dv_vld_r[DivStages-1];
  assign q_cls = dv_cls_r[DivStages-1];
  assign q_val = dv_q_r[DivStages-1];
  assign seg   = {1'b0, q_val[FracBits-1:FracBits-2]};
  assign wgt   = {q_val[FracBits-3:0], 2'b00};
  assign ca    = heat_step(seg);
  assign cb    = heat_step(seg + 3'd1);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc[j] = (FracBits+9)'(ca[j]) * (FracBits+9)'((FracBits+1)'(1) << FracBits) -
               (FracBits+9)'(ca[j]) * (FracBits+9)'(wgt) +
               (FracBits+9)'(cb[j]) * (FracBits+9)'(wgt) + (FracBits+9)'(Half);
      mix[j] = acc[j][FracBits+7:FracBits];
    end
  end

  logic  o_vld_r, o_miss_r;
  rgba_t o_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else        o_vld_r <= q_vld;
    o_miss_r <= (q_cls == CLS_MISS);
    unique case (q_cls)
      CLS_MISS:  o_col_r <= invalid_r;
      CLS_DARK:  o_col_r <= heat_step(3'd0);
      CLS_LIGHT: o_col_r <= heat_step(3'd4);
      default:   o_col_r <= mix;
    endcase
  end

  assign out_valid        = o_vld_r;
  assign out_red          = o_col_r[3];
  assign out_green        = o_col_r[2];
  assign out_blue         = o_col_r[1];
  assign out_alpha        = o_col_r[0];
  assign out_time_missing = o_miss_r;

  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> ##(DivStages + 1) out_valid)
    else $error("result word lost in pipeline");
  a_present_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_time_missing |-> out_alpha == 8'd255)
    else $error("present value without opaque alpha");
  a_blend_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[0] && dv_cls_r[0] == CLS_BLEND |-> dv_rem_r[0] < dv_den_r[0])
    else $error("divider remainder out of range");
  a_no_spurious: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_vld_r)
    else $error("valid after reset");

endmodule
